[design/jac_pkg.sv]
// shared widths, constants and rounding function for the jacobi eigen block
package jac_pkg;

  localparam int DATA_W  = 32;
  localparam int FRAC_W  = 20;
  localparam int MUL_W   = DATA_W + 1;
  localparam int PROD_W  = 2 * MUL_W;
  localparam int ACC_W   = PROD_W + 1;
  localparam int DEN_W   = DATA_W + 1;
  localparam int NUM_W   = DEN_W + FRAC_W;
  localparam int RAD_W   = 2 * DATA_W;
  localparam int ROOT_W  = DATA_W;
  localparam int TM_W    = FRAC_W + 1;
  localparam int ADDR_W  = 5;
  localparam int CNT_W   = 6;

  localparam logic [RAD_W-1:0] ONE_Q2 = RAD_W'(1) << (2 * FRAC_W);

  localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(1) << (FRAC_W - 1);
  localparam logic signed [ACC_W-1:0] SAT_HI =
    {{(ACC_W - DATA_W + 1){1'b0}}, {(DATA_W - 1){1'b1}}};
  localparam logic signed [ACC_W-1:0] SAT_LO = ~SAT_HI;
  localparam logic signed [DATA_W-1:0] DMAX = {1'b0, {(DATA_W - 1){1'b1}}};
  localparam logic signed [DATA_W-1:0] DMIN = {1'b1, {(DATA_W - 1){1'b0}}};

  // configuration register indexes
  localparam logic CFG_TOL   = 1'b0;
  localparam logic CFG_MAXSW = 1'b1;

  // round to nearest with ties up, drop the fraction, saturate
  function automatic logic signed [DATA_W-1:0] round_sat(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] q;
    q = (v + ROUND_HALF) >>> FRAC_W;
    if (q > SAT_HI) round_sat = DMAX;
    else if (q < SAT_LO) round_sat = DMIN;
    else round_sat = q[DATA_W-1:0];
  endfunction

endpackage

[design/jac_mul.sv]
// registered signed multiplier shared by all products
module jac_mul (
  input  logic                              clk,
  input  logic signed [jac_pkg::MUL_W-1:0]  a,
  input  logic signed [jac_pkg::MUL_W-1:0]  b,
  output logic signed [jac_pkg::PROD_W-1:0] p_r
);

  always_ff @(posedge clk) begin
    p_r <= a * b;
  end

endmodule

[design/jac_div.sv]
// restoring divider, one quotient bit per cycle
module jac_div (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  logic [jac_pkg::NUM_W-1:0]       num,
  input  logic [jac_pkg::DEN_W-1:0]       den,
  output logic [jac_pkg::NUM_W-1:0]       quo,
  output logic                            done_r
);

  logic                        busy_r;
  logic [jac_pkg::CNT_W-1:0]   cnt_r;
  logic [jac_pkg::DEN_W:0]     rem_r;
  logic [jac_pkg::DEN_W:0]     rem_sh;
  logic [jac_pkg::DEN_W:0]     rem_nxt;
  logic [jac_pkg::NUM_W-1:0]   qs_r;
  logic [jac_pkg::DEN_W-1:0]   den_r;
  logic                        ge;

  assign rem_sh  = {rem_r[jac_pkg::DEN_W-1:0], qs_r[jac_pkg::NUM_W-1]};
  assign ge      = rem_sh >= {1'b0, den_r};
  assign rem_nxt = ge ? rem_sh - {1'b0, den_r} : rem_sh;
  assign quo     = qs_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        rem_r  <= '0;
        qs_r   <= num;
        den_r  <= den;
      end else if (busy_r) begin
        rem_r <= rem_nxt;
        qs_r  <= {qs_r[jac_pkg::NUM_W-2:0], ge};
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == jac_pkg::CNT_W'(jac_pkg::NUM_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

endmodule

[design/jac_sqrt.sv]
// digit-by-digit integer square root, one root bit per cycle
module jac_sqrt (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [jac_pkg::RAD_W-1:0]     rad,
  output logic [jac_pkg::ROOT_W-1:0]    root_r,
  output logic                          done_r
);

  localparam int REM_W = jac_pkg::ROOT_W + 3;

  logic                        busy_r;
  logic [jac_pkg::CNT_W-1:0]   cnt_r;
  logic [REM_W-1:0]            rem_r;
  logic [REM_W-1:0]            rem_sh;
  logic [REM_W-1:0]            trial;
  logic [jac_pkg::RAD_W-1:0]   rad_r;
  logic                        ge;

  assign rem_sh = {rem_r[REM_W-3:0], rad_r[jac_pkg::RAD_W-1 -: 2]};
  assign trial  = {1'b0, root_r, 2'b01};
  assign ge     = rem_sh >= trial;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        rem_r  <= '0;
        root_r <= '0;
        rad_r  <= rad;
      end else if (busy_r) begin
        rem_r  <= ge ? rem_sh - trial : rem_sh;
        root_r <= {root_r[jac_pkg::ROOT_W-2:0], ge};
        rad_r  <= {rad_r[jac_pkg::RAD_W-3:0], 2'b00};
        cnt_r  <= cnt_r + 1'b1;
        if (cnt_r == jac_pkg::CNT_W'(jac_pkg::ROOT_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

endmodule

[design/jacobi_eigen_3x3.sv]
// top level: element store, sequencer and rotation datapath of the 3x3 jacobi solver
// Load items write at most one element of the matrix or of the rotation each and are taken one
// a cycle while the block is idle; the item marked last starts the solve and in_ready stays
// low until the eighteenth result has been loaded into the output register. Each sweep
// starts with a norm check; each of its three rotations takes three passes of the
// bit-serial divider, two passes of the bit-serial square root and the read, multiply and
// write-back steps through the single multiplier and the element store, which has one
// read and one write port. A rotation with a zero pivot skips the divider and the square
// root. Results leave one at a time while out_ready is high; the next is loaded only once
// the output register has been emptied.
module jacobi_eigen_3x3 (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic                              cfg_index,
  input  logic [30:0]                       cfg_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              in_func,
  input  logic [3:0]                        in_elem_index,
  input  logic signed [jac_pkg::DATA_W-1:0] in_elem_value,
  input  logic                              in_load_last,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              out_matrix,
  output logic [3:0]                        out_index,
  output logic signed [jac_pkg::DATA_W-1:0] out_value,
  output logic [7:0]                        out_sweep_count,
  output logic                              out_last
);

  typedef enum logic [29:0] {
    ST_IDLE    = 30'd1 << 0,
    ST_ND_RD   = 30'd1 << 1,
    ST_ND_SQ   = 30'd1 << 2,
    ST_ND_ACC  = 30'd1 << 3,
    ST_ND_TOL  = 30'd1 << 4,
    ST_ND_CMP  = 30'd1 << 5,
    ST_SC_RD0  = 30'd1 << 6,
    ST_SC_RD1  = 30'd1 << 7,
    ST_SC_RD2  = 30'd1 << 8,
    ST_SC_RD3  = 30'd1 << 9,
    ST_SC_DIV1 = 30'd1 << 10,
    ST_SC_SQ1  = 30'd1 << 11,
    ST_SC_SQ1W = 30'd1 << 12,
    ST_SC_RT1  = 30'd1 << 13,
    ST_SC_DIV2 = 30'd1 << 14,
    ST_SC_SQ2  = 30'd1 << 15,
    ST_SC_SQ2W = 30'd1 << 16,
    ST_SC_RT2  = 30'd1 << 17,
    ST_SC_DIV3 = 30'd1 << 18,
    ST_SC_S    = 30'd1 << 19,
    ST_SC_SW   = 30'd1 << 20,
    ST_RT_RX   = 30'd1 << 21,
    ST_RT_RY   = 30'd1 << 22,
    ST_RT_M1   = 30'd1 << 23,
    ST_RT_M2   = 30'd1 << 24,
    ST_RT_M3   = 30'd1 << 25,
    ST_RT_M4   = 30'd1 << 26,
    ST_RT_M5   = 30'd1 << 27,
    ST_OUT_RD  = 30'd1 << 28,
    ST_OUT_LD  = 30'd1 << 29
  } state_t;

  localparam logic [1:0] ROT_RCOL = 2'd0;
  localparam logic [1:0] ROT_ACOL = 2'd1;
  localparam logic [1:0] ROT_AROW = 2'd2;
  localparam logic [1:0] PAIR_LAST = 2'd2;
  localparam int ADDR_W = jac_pkg::ADDR_W;
  localparam logic [ADDR_W-1:0] R_BASE = ADDR_W'(9);
  localparam logic [4:0] OUT_LAST_CNT = 5'd17;

  state_t st_r, st_nxt;

  logic signed [jac_pkg::DATA_W-1:0] mem [18];
  logic signed [jac_pkg::DATA_W-1:0] rd_data_r;
  logic [ADDR_W-1:0]                 rd_addr, wr_addr;
  logic signed [jac_pkg::DATA_W-1:0] wr_data;
  logic                              wr_en;

  logic [30:0] tol_r;
  logic [7:0]  max_r;
  logic [7:0]  sweeps_r;

  logic [1:0]  nd_cnt_r;
  logic [63:0] nd_acc_r;
  logic [1:0]  pair_r, k_r, ph_r;
  logic [4:0]  out_cnt_r;

  logic signed [jac_pkg::DATA_W-1:0] apq_r, ajj_r, x_r, y_r, s_r;
  logic neg_r, tneg_r;
  logic [jac_pkg::DATA_W-1:0] atau_r;
  logic [jac_pkg::TM_W-1:0]   tm_r, c_r;
  logic signed [jac_pkg::PROD_W-1:0] acc_r;

  logic signed [jac_pkg::MUL_W-1:0]  mul_a, mul_b;
  logic signed [jac_pkg::PROD_W-1:0] p_r;
  logic signed [jac_pkg::ACC_W-1:0]  p_ext, acc_ext;

  logic                         div_start, div_done;
  logic [jac_pkg::NUM_W-1:0]    div_num, quo;
  logic [jac_pkg::DEN_W-1:0]    div_den;
  logic                         sq_start, sq_done;
  logic [jac_pkg::RAD_W-1:0]    sq_rad;
  logic [jac_pkg::ROOT_W-1:0]   root;

  logic signed [jac_pkg::DEN_W-1:0] num_s;
  logic [jac_pkg::DEN_W-1:0]        num_mag, den_mag;
  logic [ADDR_W-1:0] ai, aj, a_ii, a_jj, a_ij, p_addr, q_addr, k3, base;
  logic [ADDR_W-1:0] nd_addr;
  logic signed [jac_pkg::TM_W:0] t_s;
  logic in_acc, out_acc;

  localparam logic [jac_pkg::NUM_W-1:0] TAU_POS_LIM =
    {{(jac_pkg::NUM_W - jac_pkg::DATA_W + 1){1'b0}}, {(jac_pkg::DATA_W - 1){1'b1}}};
  localparam logic [jac_pkg::NUM_W-1:0] TAU_NEG_LIM = TAU_POS_LIM + 1'b1;

  assign in_ready = (st_r == ST_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign out_acc  = out_valid && out_ready;

  // pair order (1,0), (2,0), (2,1)
  assign ai    = (pair_r == 2'd0) ? ADDR_W'(1) : ADDR_W'(2);
  assign aj    = (pair_r == PAIR_LAST) ? ADDR_W'(1) : ADDR_W'(0);
  assign a_ii  = ai * ADDR_W'(3) + ai;
  assign a_jj  = aj * ADDR_W'(3) + aj;
  assign a_ij  = ai * ADDR_W'(3) + aj;
  assign k3    = ADDR_W'(k_r) * ADDR_W'(3);
  assign base  = (ph_r == ROT_RCOL) ? R_BASE : ADDR_W'(0);
  assign p_addr = (ph_r == ROT_AROW) ? ai * ADDR_W'(3) + ADDR_W'(k_r) : base + k3 + ai;
  assign q_addr = (ph_r == ROT_AROW) ? aj * ADDR_W'(3) + ADDR_W'(k_r) : base + k3 + aj;

  always_comb begin
    case (nd_cnt_r)
      2'd0:    nd_addr = ADDR_W'(3);
      2'd1:    nd_addr = ADDR_W'(6);
      default: nd_addr = ADDR_W'(7);
    endcase
  end

  assign num_s   = {ajj_r[jac_pkg::DATA_W-1], ajj_r} - {rd_data_r[jac_pkg::DATA_W-1], rd_data_r};
  assign num_mag = num_s[jac_pkg::DEN_W-1] ? jac_pkg::DEN_W'(-num_s) : num_s;
  assign den_mag = apq_r[jac_pkg::DATA_W-1] ? jac_pkg::DEN_W'(-{apq_r, 1'b0})
                                            : {apq_r, 1'b0};
  assign t_s     = tneg_r ? -$signed({1'b0, tm_r}) : $signed({1'b0, tm_r});

  assign p_ext   = {p_r[jac_pkg::PROD_W-1], p_r};
  assign acc_ext = {acc_r[jac_pkg::PROD_W-1], acc_r};

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_data_r <= mem[rd_addr];
  end

  always_comb begin
    rd_addr = '0;
    case (st_r)
      ST_ND_RD:  rd_addr = nd_addr;
      ST_SC_RD0: rd_addr = a_ij;
      ST_SC_RD1: rd_addr = a_jj;
      ST_SC_RD2: rd_addr = a_ii;
      ST_RT_RX:  rd_addr = p_addr;
      ST_RT_RY:  rd_addr = q_addr;
      ST_OUT_RD: rd_addr = out_cnt_r;
      default:   rd_addr = '0;
    endcase
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = p_addr;
    wr_data = jac_pkg::round_sat(acc_ext - p_ext);
    case (st_r)
      ST_IDLE: begin
        wr_en   = in_acc && (in_elem_index < 4'd9);
        wr_addr = ADDR_W'(in_elem_index) + (in_func ? R_BASE : ADDR_W'(0));
        wr_data = in_elem_value;
      end
      ST_RT_M3: wr_en = 1'b1;
      ST_RT_M5: begin
        wr_en   = 1'b1;
        wr_addr = q_addr;
        wr_data = jac_pkg::round_sat(acc_ext + p_ext);
      end
      default: wr_en = 1'b0;
    endcase
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (st_r)
      ST_ND_SQ: begin
        mul_a = rd_data_r[jac_pkg::DATA_W-1] ? -{rd_data_r[jac_pkg::DATA_W-1], rd_data_r}
                                             : {1'b0, rd_data_r};
        mul_b = mul_a;
      end
      ST_ND_TOL: begin
        mul_a = {2'b00, tol_r};
        mul_b = {2'b00, tol_r};
      end
      ST_SC_SQ1: begin
        mul_a = {1'b0, atau_r};
        mul_b = {1'b0, atau_r};
      end
      ST_SC_SQ2: begin
        mul_a = jac_pkg::MUL_W'(tm_r);
        mul_b = jac_pkg::MUL_W'(tm_r);
      end
      ST_SC_S: begin
        mul_a = jac_pkg::MUL_W'(c_r);
        mul_b = jac_pkg::MUL_W'(t_s);
      end
      ST_RT_M1: begin
        mul_a = jac_pkg::MUL_W'(c_r);
        mul_b = jac_pkg::MUL_W'(x_r);
      end
      ST_RT_M2: begin
        mul_a = jac_pkg::MUL_W'(s_r);
        mul_b = jac_pkg::MUL_W'(y_r);
      end
      ST_RT_M3: begin
        mul_a = jac_pkg::MUL_W'(s_r);
        mul_b = jac_pkg::MUL_W'(x_r);
      end
      ST_RT_M4: begin
        mul_a = jac_pkg::MUL_W'(c_r);
        mul_b = jac_pkg::MUL_W'(y_r);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  jac_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p_r (p_r)
  );

  always_comb begin
    div_start = 1'b0;
    div_num   = {num_mag, {jac_pkg::FRAC_W{1'b0}}};
    div_den   = den_mag;
    sq_start  = 1'b0;
    sq_rad    = p_r[jac_pkg::RAD_W-1:0] + jac_pkg::ONE_Q2;
    case (st_r)
      ST_SC_RD3:  div_start = (apq_r != '0);
      ST_SC_SQ1W: sq_start = 1'b1;
      ST_SC_SQ2W: sq_start = 1'b1;
      ST_SC_RT1: begin
        div_start = sq_done;
        div_num   = jac_pkg::NUM_W'(jac_pkg::ONE_Q2);
        div_den   = {1'b0, atau_r} + {1'b0, root};
      end
      ST_SC_RT2: begin
        div_start = sq_done;
        div_num   = jac_pkg::NUM_W'(jac_pkg::ONE_Q2);
        div_den   = {1'b0, root};
      end
      default: div_start = 1'b0;
    endcase
  end

  jac_div u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (div_start),
    .num    (div_num),
    .den    (div_den),
    .quo    (quo),
    .done_r (div_done)
  );

  jac_sqrt u_sqrt (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (sq_start),
    .rad    (sq_rad),
    .root_r (root),
    .done_r (sq_done)
  );

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      ST_IDLE:    if (in_acc && in_load_last) st_nxt = ST_ND_RD;
      ST_ND_RD:   st_nxt = ST_ND_SQ;
      ST_ND_SQ:   st_nxt = ST_ND_ACC;
      ST_ND_ACC:  st_nxt = (nd_cnt_r == 2'd2) ? ST_ND_TOL : ST_ND_RD;
      ST_ND_TOL:  st_nxt = ST_ND_CMP;
      ST_ND_CMP:  st_nxt = (nd_acc_r > p_r[63:0] && sweeps_r < max_r) ? ST_SC_RD0
                                                                      : ST_OUT_RD;
      ST_SC_RD0:  st_nxt = ST_SC_RD1;
      ST_SC_RD1:  st_nxt = ST_SC_RD2;
      ST_SC_RD2:  st_nxt = ST_SC_RD3;
      ST_SC_RD3:  st_nxt = (apq_r == '0) ? ST_RT_RX : ST_SC_DIV1;
      ST_SC_DIV1: if (div_done) st_nxt = ST_SC_SQ1;
      ST_SC_SQ1:  st_nxt = ST_SC_SQ1W;
      ST_SC_SQ1W: st_nxt = ST_SC_RT1;
      ST_SC_RT1:  if (sq_done) st_nxt = ST_SC_DIV2;
      ST_SC_DIV2: if (div_done) st_nxt = ST_SC_SQ2;
      ST_SC_SQ2:  st_nxt = ST_SC_SQ2W;
      ST_SC_SQ2W: st_nxt = ST_SC_RT2;
      ST_SC_RT2:  if (sq_done) st_nxt = ST_SC_DIV3;
      ST_SC_DIV3: if (div_done) st_nxt = ST_SC_S;
      ST_SC_S:    st_nxt = ST_SC_SW;
      ST_SC_SW:   st_nxt = ST_RT_RX;
      ST_RT_RX:   st_nxt = ST_RT_RY;
      ST_RT_RY:   st_nxt = ST_RT_M1;
      ST_RT_M1:   st_nxt = ST_RT_M2;
      ST_RT_M2:   st_nxt = ST_RT_M3;
      ST_RT_M3:   st_nxt = ST_RT_M4;
      ST_RT_M4:   st_nxt = ST_RT_M5;
      ST_RT_M5: begin
        if (k_r != 2'd2 || ph_r != ROT_AROW) st_nxt = ST_RT_RX;
        else if (pair_r == PAIR_LAST) st_nxt = ST_ND_RD;
        else st_nxt = ST_SC_RD0;
      end
      ST_OUT_RD:  if (!out_valid) st_nxt = ST_OUT_LD;
      ST_OUT_LD:  st_nxt = (out_cnt_r == OUT_LAST_CNT) ? ST_IDLE : ST_OUT_RD;
      default:    st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r      <= ST_IDLE;
      tol_r     <= 31'd1049;
      max_r     <= 8'd101;
      sweeps_r  <= '0;
      out_valid <= 1'b0;
      out_cnt_r <= '0;
      nd_cnt_r  <= '0;
      pair_r    <= '0;
      k_r       <= '0;
      ph_r      <= ROT_RCOL;
    end else begin
      st_r <= st_nxt;
      if (cfg_we) begin
        if (cfg_index == jac_pkg::CFG_TOL) tol_r <= cfg_data;
        else if (cfg_index == jac_pkg::CFG_MAXSW) max_r <= cfg_data[7:0];
      end
      if (out_acc) out_valid <= 1'b0;
      case (st_r)
        ST_IDLE: begin
          if (in_acc && in_load_last) begin
            sweeps_r <= '0;
            nd_cnt_r <= '0;
            nd_acc_r <= '0;
          end
        end
        ST_ND_ACC: begin
          nd_acc_r <= nd_acc_r + p_r[63:0];
          nd_cnt_r <= nd_cnt_r + 1'b1;
        end
        ST_ND_CMP: begin
          out_cnt_r <= '0;
          pair_r    <= '0;
          k_r       <= '0;
          ph_r      <= ROT_RCOL;
          if (nd_acc_r > p_r[63:0] && sweeps_r < max_r) sweeps_r <= sweeps_r + 1'b1;
        end
        ST_SC_RD1: apq_r <= rd_data_r;
        ST_SC_RD2: ajj_r <= rd_data_r;
        ST_SC_RD3: begin
          // zero pivot rotates with c = 1, s = 0
          neg_r <= num_s[jac_pkg::DEN_W-1] ^ apq_r[jac_pkg::DATA_W-1];
          c_r   <= jac_pkg::TM_W'(1) << jac_pkg::FRAC_W;
          s_r   <= '0;
        end
        ST_SC_DIV1: begin
          if (div_done) begin
            if (neg_r) begin
              atau_r <= (quo > TAU_NEG_LIM) ? TAU_NEG_LIM[jac_pkg::DATA_W-1:0]
                                            : quo[jac_pkg::DATA_W-1:0];
              tneg_r <= (quo != '0);
            end else begin
              atau_r <= (quo > TAU_POS_LIM) ? TAU_POS_LIM[jac_pkg::DATA_W-1:0]
                                            : quo[jac_pkg::DATA_W-1:0];
              tneg_r <= 1'b0;
            end
          end
        end
        ST_SC_DIV2: if (div_done) tm_r <= quo[jac_pkg::TM_W-1:0];
        ST_SC_DIV3: if (div_done) c_r <= quo[jac_pkg::TM_W-1:0];
        ST_SC_SW:   s_r <= jac_pkg::round_sat(p_ext);
        ST_RT_RY:   x_r <= rd_data_r;
        ST_RT_M1:   y_r <= rd_data_r;
        ST_RT_M2:   acc_r <= p_r;
        ST_RT_M4:   acc_r <= p_r;
        ST_RT_M5: begin
          if (k_r != 2'd2) begin
            k_r <= k_r + 1'b1;
          end else begin
            k_r <= '0;
            if (ph_r != ROT_AROW) begin
              ph_r <= ph_r + 1'b1;
            end else begin
              ph_r     <= ROT_RCOL;
              pair_r   <= (pair_r == PAIR_LAST) ? 2'd0 : pair_r + 1'b1;
              nd_cnt_r <= '0;
              nd_acc_r <= '0;
            end
          end
        end
        ST_OUT_LD: begin
          out_valid       <= 1'b1;
          out_value       <= rd_data_r;
          out_matrix      <= (out_cnt_r >= 5'd9);
          out_index       <= (out_cnt_r >= 5'd9) ? 4'(out_cnt_r - 5'd9) : out_cnt_r[3:0];
          out_last        <= (out_cnt_r == OUT_LAST_CNT);
          out_sweep_count <= sweeps_r;
          out_cnt_r       <= out_cnt_r + 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  // the output register is free whenever a new item is loaded into it
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == ST_OUT_LD |-> !out_valid)
    else $error("output item overwritten");

  a_div_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (st_r == ST_SC_DIV1 || st_r == ST_SC_DIV2 || st_r == ST_SC_DIV3))
    else $error("divider finished outside a wait state");

  a_sqrt_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
    sq_done |-> (st_r == ST_SC_RT1 || st_r == ST_SC_RT2))
    else $error("square root finished outside a wait state");

  a_load_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_RT_M3 || st_r == ST_RT_M5) |-> !in_ready)
    else $error("load accepted during rotation write-back");

endmodule

[tb/jacobi_eigen_3x3_tb.sv]
// testbench for the 3x3 jacobi eigen solver: table-driven and random loads checked against a predictor
`timescale 1ns / 100ps

module jacobi_eigen_3x3_tb;

  localparam logic FN_MAT = 1'b0;
  localparam logic FN_ROT = 1'b1;
  localparam int   CYCLE_LIMIT = 2_000_000;
  localparam longint QONE = 64'sd1 << jac_pkg::FRAC_W;

  typedef struct {
    logic        func;
    logic [3:0]  idx;
    logic [31:0] value;
    logic        last;
    int          exp_sweeps;   // -1: taken from the predictor only
  } load_t;

  typedef struct {
    logic        matrix;
    logic [3:0]  idx;
    logic [31:0] value;
    logic [7:0]  sweeps;
    logic        last;
  } elem_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic cfg_index = 1'b0;
  logic [30:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic in_func = 1'b0;
  logic [3:0] in_elem_index = '0;
  logic signed [jac_pkg::DATA_W-1:0] in_elem_value = '0;
  logic in_load_last = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic out_matrix;
  logic [3:0] out_index;
  logic signed [jac_pkg::DATA_W-1:0] out_value;
  logic [7:0] out_sweep_count;
  logic out_last;

  jacobi_eigen_3x3 u_dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .in_func(in_func),
    .in_elem_index(in_elem_index), .in_elem_value(in_elem_value),
    .in_load_last(in_load_last),
    .out_valid(out_valid), .out_ready(out_ready), .out_matrix(out_matrix),
    .out_index(out_index), .out_value(out_value),
    .out_sweep_count(out_sweep_count), .out_last(out_last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state
  longint          work_m[9];
  longint          rot_m[9];
  longint unsigned tol_q;
  int              sweep_limit;
  elem_t           pending_elems[$];

  int errors = 0;
  int n_items = 0;
  int n_solves = 0;
  int n_results = 0;
  int most_sweeps = 0;
  int send_idle = 0;
  int recv_stall = 0;
  int hold_req = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int cycles = 0;

  task automatic report(input string what);
    errors++;
    $display("MISMATCH @%0t: %s", $realtime, what);
  endtask

  function automatic longint clamp32(input longint x);
    if (x > 64'sd2147483647) return 64'sd2147483647;
    if (x < -64'sd2147483648) return -64'sd2147483648;
    return x;
  endfunction

  // nearest, ties up, then saturate
  function automatic longint rnd_q(input longint p);
    return clamp32((p + (64'sd1 << (jac_pkg::FRAC_W - 1))) >>> jac_pkg::FRAC_W);
  endfunction

  function automatic longint unsigned magn(input longint x);
    return x < 0 ? 64'd0 - longint'(x) : x;
  endfunction

  function automatic longint unsigned int_sqrt(input longint unsigned x);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv >>= 2;
    while (bitv != 0) begin
      if (x >= res + bitv) begin
        x -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  function automatic void apply_rotation(input int i, input int j);
    longint apq, num, den, tau, t, c, s, x, y;
    longint unsigned q, atau, d, tm;
    bit neg;
    apq = work_m[i*3+j];
    c = QONE;
    s = 0;
    if (apq != 0) begin
      num = work_m[j*3+j] - work_m[i*3+i];
      den = 2 * apq;
      q = (magn(num) << jac_pkg::FRAC_W) / magn(den);
      neg = (num < 0) != (den < 0);
      if (neg) tau = (q > 64'd2147483648) ? -64'sd2147483648 : -longint'(q);
      else tau = (q > 64'd2147483647) ? 64'sd2147483647 : longint'(q);
      atau = magn(tau);
      d = atau + int_sqrt(atau * atau + (64'd1 << (2*jac_pkg::FRAC_W)));
      tm = (64'd1 << (2*jac_pkg::FRAC_W)) / d;
      t = (tau >= 0) ? longint'(tm) : -longint'(tm);
      c = longint'((64'd1 << (2*jac_pkg::FRAC_W)) /
                   int_sqrt(tm * tm + (64'd1 << (2*jac_pkg::FRAC_W))));
      s = rnd_q(c * t);
    end
    for (int k = 0; k < 3; k++) begin
      x = rot_m[k*3+i]; y = rot_m[k*3+j];
      rot_m[k*3+i] = rnd_q(c*x - s*y);
      rot_m[k*3+j] = rnd_q(s*x + c*y);
    end
    for (int k = 0; k < 3; k++) begin
      x = work_m[k*3+i]; y = work_m[k*3+j];
      work_m[k*3+i] = rnd_q(c*x - s*y);
      work_m[k*3+j] = rnd_q(s*x + c*y);
    end
    for (int k = 0; k < 3; k++) begin
      x = work_m[i*3+k]; y = work_m[j*3+k];
      work_m[i*3+k] = rnd_q(c*x - s*y);
      work_m[j*3+k] = rnd_q(s*x + c*y);
    end
  endfunction

  function automatic bit off_diag_above_tol();
    longint unsigned a, b, e;
    a = magn(work_m[3]); b = magn(work_m[6]); e = magn(work_m[7]);
    return (a*a + b*b + e*e) > tol_q * tol_q;
  endfunction

  // returns the sweep count when the item starts a solve, else -1
  function automatic int predict_load(input load_t it);
    int sw;
    elem_t e;
    if (it.idx < 9) begin
      if (it.func == FN_ROT) rot_m[it.idx] = longint'(signed'(it.value));
      else work_m[it.idx] = longint'(signed'(it.value));
    end
    if (!it.last) return -1;
    sw = 0;
    while (off_diag_above_tol() && sw < sweep_limit) begin
      sw++;
      apply_rotation(1, 0);
      apply_rotation(2, 0);
      apply_rotation(2, 1);
    end
    for (int k = 0; k < 18; k++) begin
      e.matrix = (k >= 9);
      e.idx = 4'(k % 9);
      e.value = (k < 9) ? work_m[k][31:0] : rot_m[k-9][31:0];
      e.sweeps = 8'(sw);
      e.last = (k == 17);
      pending_elems.push_back(e);
    end
    return sw;
  endfunction

  task automatic send_load(input load_t it);
    int sw;
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_func <= it.func;
    in_elem_index <= it.idx;
    in_elem_value <= it.value;
    in_load_last <= it.last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    n_items++;
    sw = predict_load(it);
    if (sw >= 0) begin
      n_solves++;
      if (sw > most_sweeps) most_sweeps = sw;
      if (it.exp_sweeps >= 0 && it.exp_sweeps != sw)
        report($sformatf("sweep count %0d, table says %0d", sw, it.exp_sweeps));
    end
  endtask

  // drain results, then let the block settle before touching registers
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_elems.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input longint unsigned v);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= 31'(v);
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == jac_pkg::CFG_TOL) tol_q = v & 64'h7FFF_FFFF;
    else sweep_limit = int'(v & 64'hFF);
    @(posedge clk);
  endtask

  // result side
  always @(posedge clk) begin
    elem_t e;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        n_results++;
        if (pending_elems.size() == 0) begin
          report($sformatf("unexpected result idx %0d", out_index));
        end else begin
          e = pending_elems.pop_front();
          if (out_matrix !== e.matrix || out_index !== e.idx || out_value !== e.value ||
              out_sweep_count !== e.sweeps || out_last !== e.last)
            report($sformatf("got m%0d[%0d]=%h sw %0d last %0b, want m%0d[%0d]=%h sw %0d last %0b",
                             out_matrix, out_index, out_value, out_sweep_count, out_last,
                             e.matrix, e.idx, e.value, e.sweeps, e.last));
        end
      end
      if (hold_req != hold_seen) begin
        hold_seen <= hold_req;
        hold_left <= 4000;
        out_ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_stall);
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("Test completed with failures");
      $finish;
    end
  end

  // directed loads; zero limit and huge tolerance echo the loaded data
  load_t dir_tab[] = '{
    '{FN_MAT, 4'd0, 32'h7FFF_FFFF, 1'b0, -1},
    '{FN_MAT, 4'd1, 32'h8000_0000, 1'b0, -1},
    '{FN_MAT, 4'd2, 32'h0000_0000, 1'b0, -1},
    '{FN_MAT, 4'd3, 32'hFFFF_FFFF, 1'b0, -1},
    '{FN_MAT, 4'd4, 32'h0010_0000, 1'b0, -1},
    '{FN_MAT, 4'd5, 32'h5555_5555, 1'b0, -1},
    '{FN_MAT, 4'd6, 32'hAAAA_AAAA, 1'b0, -1},
    '{FN_MAT, 4'd7, 32'h0000_0007, 1'b0, -1},
    '{FN_MAT, 4'd8, 32'h0000_0003, 1'b0, -1},
    '{FN_ROT, 4'd0, 32'h0010_0000, 1'b0, -1},
    '{FN_ROT, 4'd1, 32'h8000_0000, 1'b0, -1},
    '{FN_ROT, 4'd2, 32'h7FFF_FFFF, 1'b0, -1},
    '{FN_ROT, 4'd3, 32'h0000_0000, 1'b0, -1},
    '{FN_ROT, 4'd4, 32'h0010_0000, 1'b0, -1},
    '{FN_ROT, 4'd5, 32'hFFFF_FFFF, 1'b0, -1},
    '{FN_ROT, 4'd6, 32'h0000_0001, 1'b0, -1},
    '{FN_ROT, 4'd7, 32'h0000_0000, 1'b0, -1},
    '{FN_ROT, 4'd8, 32'h0010_0000, 1'b1,  0},
    // out-of-range index writes nothing but still starts
    '{FN_MAT, 4'd15, 32'h8000_0000, 1'b1, 0},
    // equal diagonal (zero tau) and a zero pivot
    '{FN_MAT, 4'd0, 32'h0010_0000, 1'b0, -1},
    '{FN_MAT, 4'd4, 32'h0010_0000, 1'b0, -1},
    '{FN_MAT, 4'd8, 32'h0030_0000, 1'b0, -1},
    '{FN_MAT, 4'd1, 32'h0004_0000, 1'b0, -1},
    '{FN_MAT, 4'd3, 32'h0004_0000, 1'b0, -1},
    '{FN_MAT, 4'd2, 32'h0000_0000, 1'b0, -1},
    '{FN_MAT, 4'd6, 32'h0000_0000, 1'b0, -1},
    '{FN_MAT, 4'd5, 32'h0002_0000, 1'b0, -1},
    '{FN_MAT, 4'd7, 32'h0002_0000, 1'b1, -1}
  };

  initial begin
    load_t it;
    longint sym[9];
    int order[9];
    int mode, n, tmp, p;
    tol_q = 1049;
    sweep_limit = 101;
    for (int k = 0; k < 9; k++) begin
      work_m[k] = 0;
      rot_m[k] = 0;
    end
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    write_reg(jac_pkg::CFG_MAXSW, 0);
    write_reg(jac_pkg::CFG_TOL, 0);
    for (int r = 0; r < dir_tab.size(); r++) begin
      if (r == 18) begin
        wait_idle();
        write_reg(jac_pkg::CFG_MAXSW, 255);
        write_reg(jac_pkg::CFG_TOL, 64'h7FFF_FFFF);
      end else if (r == 19) begin
        wait_idle();
        write_reg(jac_pkg::CFG_TOL, 0);
      end
      send_load(dir_tab[r]);
    end

    while (n_items < 470) begin
      wait_idle();
      mode = (n_solves / 3) % 4;
      send_idle  = (mode == 1) ? 78 : (mode == 3) ? 9 : 0;
      recv_stall = (mode == 2) ? 78 : (mode == 3) ? 9 : 0;
      write_reg(jac_pkg::CFG_MAXSW, ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 6));
      case ($urandom_range(3))
        0: write_reg(jac_pkg::CFG_TOL, 0);
        1: write_reg(jac_pkg::CFG_TOL, $urandom_range(1, 5000));
        2: write_reg(jac_pkg::CFG_TOL, 1049);
        default: write_reg(jac_pkg::CFG_TOL, $urandom & 32'h7FFF_FFFF);
      endcase
      if (n_solves == 12) hold_req++;
      if ($urandom_range(7) == 0) begin
        // noise: any field, full range values, partial writes
        n = $urandom_range(3, 10);
        for (int k = 0; k < n; k++) begin
          it = '{1'($urandom_range(1)), 4'($urandom_range(15)), $urandom,
                 (k == n - 1), -1};
          send_load(it);
        end
      end else begin
        for (int a = 0; a < 3; a++)
          for (int b = 0; b <= a; b++) begin
            sym[a*3+b] = longint'($urandom_range(0, 1 << 24)) - (1 << 23);
            sym[b*3+a] = sym[a*3+b];
          end
        if ($urandom_range(1)) begin
          for (int k = 0; k < 9; k++) begin
            it = '{FN_ROT, 4'(k), (k % 4 == 0) ? 32'h0010_0000
                   : ($urandom_range(3) == 0 ? $urandom : 32'h0), 1'b0, -1};
            send_load(it);
          end
        end
        for (int k = 0; k < 9; k++) order[k] = k;
        for (int k = 8; k > 0; k--) begin
          p = $urandom_range(k);
          tmp = order[k]; order[k] = order[p]; order[p] = tmp;
        end
        for (int k = 0; k < 9; k++) begin
          it = '{FN_MAT, 4'(order[k]), sym[order[k]][31:0], (k == 8), -1};
          send_load(it);
        end
      end
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_elems.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    $display("%0d load items, %0d solves, %0d results checked, up to %0d sweeps in one solve",
             n_items, n_solves, n_results, most_sweeps);
    $display("register extremes, zero sweep limit, long receiver hold, %0d mismatches", errors);
    if (errors == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

endmodule
